// ----- hdl/dtt_pkg.sv -----
// Shared types, constants and command codes for the per-task duty throttle.
// Used by dtt_ctrl, dtt_dp and per_task_duty_throttle.
`timescale 1ns / 1ps
package dtt_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	localparam int ID_W = 17;
	localparam int LIM_W = 20;
	localparam int TIME_W = 64;
	localparam int IV_W = 32;
	localparam int STAT_W = 4;
	localparam int SHARE_SH = 16;
	localparam int B_W = LIM_W + IV_W;
	localparam int A_W = TIME_W + SHARE_SH;
	localparam int R_W = A_W + 2;
	localparam int Q_W = IV_W + 1;
	localparam int STEP_W = $clog2(IV_W);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [IV_W-1:0] IV_MIN = 32'd1000000;
	localparam logic [IV_W-1:0] IV_RESET = 32'd30000000;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED = 2'd1;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_GONE = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [STAT_W-1:0] ST_UPDATED = 4'd0;
	localparam logic [STAT_W-1:0] ST_FIRST = 4'd1;
	localparam logic [STAT_W-1:0] ST_INSERTED = 4'd2;
	localparam logic [STAT_W-1:0] ST_LIMIT_CHANGED = 4'd3;
	localparam logic [STAT_W-1:0] ST_DELETED = 4'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 4'd5;
	localparam logic [STAT_W-1:0] ST_FULL = 4'd6;
	localparam logic [STAT_W-1:0] ST_REJECTED = 4'd7;
	localparam logic [STAT_W-1:0] ST_CLEARED = 4'd8;

	typedef struct packed {
		logic [1:0]        op;
		logic [ID_W-1:0]   task_id;
		logic [LIM_W-1:0]  limit_share;
		logic [TIME_W-1:0] cpu_time_ns;
	} in_item_t;

	typedef struct packed {
		logic [IV_W-1:0]   sleep_ns;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  active_tasks;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN,
		CMD_APPLY,
		CMD_PREP,
		CMD_SETUP,
		CMD_DIV,
		CMD_FINISH,
		CMD_CLEAR,
		CMD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       hit;
		logic       last_zero;
		logic       out_free;
	} dp_status_t;

endpackage

// ----- hdl/dtt_dp.sv -----
// Datapath of the duty throttle: task table, config registers, multiply-divide unit
// and the output register. Driven by dtt_ctrl commands; uses dtt_pkg.
`timescale 1ns / 1ps
module dtt_dp
	import dtt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	// table
	logic [MAX_TASKS-1:0] valid_q;
	logic [ID_W-1:0]      id_q    [MAX_TASKS];
	logic [LIM_W-1:0]     lim_q   [MAX_TASKS];
	logic [TIME_W-1:0]    last_q  [MAX_TASKS];
	logic [IV_W-1:0]      sleep_q [MAX_TASKS];
	logic [CNT_W-1:0]     cnt_q;

	logic [IV_W-1:0] iv_q;
	logic [ID_W-1:0] excl_q;

	in_item_t         item_q;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] k_q, f_q;

	logic [TIME_W-1:0] diff_q;
	logic [IV_W-1:0]   sl_q;
	logic [B_W-1:0]    b_q;
	logic [IV_W-1:0]   work_q;
	logic              ge_q, zero_q;
	logic [A_W-1:0]    x_q, d_q;
	logic [R_W-1:0]    r_q;
	logic [Q_W-1:0]    q_q;

	logic [IV_W-1:0]   res_sleep_q;
	logic [STAT_W-1:0] res_status_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// apply decisions
	logic              id_bad, do_del, do_ins, do_setlim, do_first;
	logic [STAT_W-1:0] ap_status;
	logic [IV_W-1:0]   ap_sleep;

	// setup
	logic [A_W-1:0] a_w, bx_w;
	logic           ge_w;

	// divide step
	logic [R_W-1:0] t_w, d1_w, d2_w, r_nx;
	logic [1:0]     qa_w;

	// finish
	logic [Q_W:0]    sum_w, qc_w;
	logic [IV_W-1:0] fin_w;

	assign id_bad = (item_q.task_id == '0) || (item_q.task_id == excl_q);

	always_comb begin
		do_del = 1'b0;
		do_ins = 1'b0;
		do_setlim = 1'b0;
		do_first = 1'b0;
		ap_status = ST_NOT_FOUND;
		ap_sleep = '0;
		case (item_q.op)
			OP_SET: begin
				if (id_bad) begin
					ap_status = ST_REJECTED;
				end else if (hit_q) begin
					if (item_q.limit_share == '0) begin
						do_del = 1'b1;
						ap_status = ST_DELETED;
					end else begin
						do_setlim = 1'b1;
						ap_status = ST_LIMIT_CHANGED;
					end
				end else if (item_q.limit_share == '0) begin
					ap_status = ST_NOT_FOUND;
				end else if (free_q) begin
					do_ins = 1'b1;
					ap_status = ST_INSERTED;
				end else begin
					ap_status = ST_FULL;
				end
			end
			OP_SAMPLE: begin
				// the computed-update path never issues an apply
				if (hit_q) begin
					do_first = 1'b1;
					ap_status = ST_FIRST;
					ap_sleep = sleep_q[k_q];
				end
			end
			OP_GONE: begin
				if (hit_q) begin
					do_del = 1'b1;
					ap_status = ST_DELETED;
				end
			end
			default: begin
				ap_status = ST_CLEARED;
			end
		endcase
	end

	assign a_w = {diff_q, {SHARE_SH{1'b0}}};
	assign bx_w = A_W'(b_q);
	assign ge_w = (a_w >= bx_w);

	// one bit of work per step: r = 2r + bit*x, reduced modulo d
	assign d1_w = R_W'(d_q);
	assign d2_w = {d1_w[R_W-2:0], 1'b0};
	assign t_w = {r_q[R_W-2:0], 1'b0} + (work_q[IV_W-1] ? R_W'(x_q) : R_W'(0));
	always_comb begin
		if (t_w >= d2_w) begin
			r_nx = t_w - d2_w;
			qa_w = 2'd2;
		end else if (t_w >= d1_w) begin
			r_nx = t_w - d1_w;
			qa_w = 2'd1;
		end else begin
			r_nx = t_w;
			qa_w = 2'd0;
		end
	end

	assign sum_w = (Q_W+1)'(sl_q) + (Q_W+1)'(q_q);
	assign qc_w = (Q_W+1)'(q_q) + (Q_W+1)'(r_q != '0);
	always_comb begin
		if (zero_q) begin
			fin_w = sl_q;
		end else if (ge_q) begin
			fin_w = (sum_w > (Q_W+1)'(iv_q)) ? iv_q : sum_w[IV_W-1:0];
		end else begin
			fin_w = (qc_w > (Q_W+1)'(sl_q)) ? '0 : sl_q - qc_w[IV_W-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			iv_q <= IV_RESET;
			excl_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INTERVAL: begin
						if (cfg_data >= IV_MIN) iv_q <= cfg_data;
					end
					REG_EXCLUDED: begin
						excl_q <= cfg_data[ID_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.op == CMD_APPLY) begin
				if (do_del) begin
					valid_q[k_q] <= 1'b0;
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (do_ins) begin
					valid_q[f_q] <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.op == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_LOAD: begin
				item_q <= in_data;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end
			CMD_SCAN: begin
				if (valid_q[cmd.idx] && id_q[cmd.idx] == item_q.task_id && !hit_q) begin
					hit_q <= 1'b1;
					k_q <= cmd.idx;
				end
				if (!valid_q[cmd.idx] && !free_q) begin
					free_q <= 1'b1;
					f_q <= cmd.idx;
				end
			end
			CMD_APPLY: begin
				if (do_setlim) lim_q[k_q] <= item_q.limit_share;
				if (do_ins) begin
					id_q[f_q] <= item_q.task_id;
					lim_q[f_q] <= item_q.limit_share;
					last_q[f_q] <= '0;
					sleep_q[f_q] <= '0;
				end
				if (do_first) last_q[k_q] <= item_q.cpu_time_ns;
				res_sleep_q <= ap_sleep;
				res_status_q <= ap_status;
			end
			CMD_PREP: begin
				diff_q <= item_q.cpu_time_ns - last_q[k_q];
				sl_q <= (sleep_q[k_q] < iv_q) ? sleep_q[k_q] : iv_q;
				b_q <= B_W'(lim_q[k_q]) * B_W'(iv_q);
			end
			CMD_SETUP: begin
				ge_q <= ge_w;
				zero_q <= (a_w == '0) && (bx_w == '0);
				x_q <= ge_w ? a_w - bx_w : bx_w - a_w;
				d_q <= ge_w ? a_w : bx_w;
				work_q <= (iv_q == sl_q) ? iv_q : iv_q - sl_q;
				r_q <= '0;
				q_q <= '0;
			end
			CMD_DIV: begin
				r_q <= r_nx;
				q_q <= {q_q[Q_W-2:0], 1'b0} + Q_W'(qa_w);
				work_q <= {work_q[IV_W-2:0], 1'b0};
			end
			CMD_FINISH: begin
				sleep_q[k_q] <= fin_w;
				last_q[k_q] <= item_q.cpu_time_ns;
				res_sleep_q <= fin_w;
				res_status_q <= ST_UPDATED;
			end
			CMD_CLEAR: begin
				last_q[cmd.idx] <= '0;
				sleep_q[cmd.idx] <= '0;
				res_sleep_q <= '0;
				res_status_q <= ST_CLEARED;
			end
			CMD_OUT: begin
				out_q.sleep_ns <= res_sleep_q;
				out_q.status <= res_status_q;
				out_q.active_tasks <= cnt_q;
			end
			default: begin
			end
		endcase
	end

	assign status.op = item_q.op;
	assign status.hit = hit_q;
	assign status.last_zero = (last_q[k_q] == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_W'($countones(valid_q)))
		else $error("active count out of step with valid bits");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_OUT |=> out_valid_q)
		else $error("result load did not raise valid");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> cmd.op != CMD_OUT)
		else $error("stalled result overwritten");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.status <= ST_CLEARED)
		else $error("status code out of range");
`endif

endmodule

// ----- hdl/dtt_ctrl.sv -----
// Controller state machine of the duty throttle: sequences table scan, update,
// divide, statistics clear and result hand-off. Issues dp_cmd_t to dtt_dp; uses dtt_pkg.
`timescale 1ns / 1ps
module dtt_ctrl
	import dtt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_PREP,
		S_SETUP,
		S_DIV,
		S_FINISH,
		S_CLEAR,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic              idx_last, calc;

	assign idx_last = (idx_q == IDX_W'(MAX_TASKS - 1));
	assign calc = (status.op == OP_SAMPLE) && status.hit && !status.last_zero;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd.op = CMD_NONE;
		cmd.idx = idx_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) cmd.op = CMD_LOAD;
			S_SCAN:   cmd.op = CMD_SCAN;
			S_DECIDE: if (status.op != OP_CLEAR && !calc) cmd.op = CMD_APPLY;
			S_PREP:   cmd.op = CMD_PREP;
			S_SETUP:  cmd.op = CMD_SETUP;
			S_DIV:    cmd.op = CMD_DIV;
			S_FINISH: cmd.op = CMD_FINISH;
			S_CLEAR:  cmd.op = CMD_CLEAR;
			S_DONE:   if (status.out_free) cmd.op = CMD_OUT;
			default:  cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_last) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					idx_q <= '0;
					if (status.op == OP_CLEAR) state_q <= S_CLEAR;
					else if (calc) state_q <= S_PREP;
					else state_q <= S_DONE;
				end
				S_PREP: state_q <= S_SETUP;
				S_SETUP: begin
					step_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(IV_W - 1)) state_q <= S_FINISH;
				end
				S_FINISH: state_q <= S_DONE;
				S_CLEAR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_last) state_q <= S_DONE;
				end
				S_DONE: if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/per_task_duty_throttle.sv -----
// Per-task duty throttle: each item is loaded, then takes one pass over the 16-entry task
// table (one entry a cycle) followed by decision and hand-off; a sample that updates the
// sleep time also runs a 32-step multiply-divide unit that handles one bit of the work
// time per cycle, and reset-statistics items make a second pass that clears the stored
// times of every entry. One item is in work at a time. The result sits in an output
// register, so the next item is taken while it waits. Writes to the REG_INTERVAL
// register below 1000000 are ignored. Uses dtt_pkg, dtt_ctrl and dtt_dp.
`timescale 1ns / 1ps
module per_task_duty_throttle
	import dtt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	dtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	dtt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
